/* src/mws_pkg.sv */
// Shared types, codes and constants of the moisture watering sequencer.
package mws_pkg;

  // Field widths
  localparam int MOISTURE_BITS = 12;
  localparam int TICK_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  // Sequencing constants
  localparam int FAIL_LIMIT_DEF = 5;
  localparam int RISE_MARGIN    = 40;

  // Register reset values
  localparam logic [MOISTURE_BITS-1:0] TARGET_RST = MOISTURE_BITS'(2048);
  localparam logic [TICK_BITS-1:0]     IDLE_RST   = TICK_BITS'(1000);
  localparam logic [TICK_BITS-1:0]     WATER_RST  = TICK_BITS'(100);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WATER  = 2'd2;

  // Phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CHECK = 2'd1;
  localparam logic [1:0] PH_WATER = 2'd2;
  localparam logic [1:0] PH_SENSE = 2'd3;

  // Valve command codes
  localparam logic [1:0] VALVE_NONE  = 2'd0;
  localparam logic [1:0] VALVE_OPEN  = 2'd1;
  localparam logic [1:0] VALVE_CLOSE = 2'd2;

  // Event kinds
  localparam logic EV_OTHER = 1'b0;
  localparam logic EV_READY = 1'b1;

  typedef struct packed {
    logic                     event_valid;
    logic                     event_kind;
    logic [MOISTURE_BITS-1:0] moisture;
  } tick_t;

  typedef struct packed {
    logic       sense_request;
    logic [1:0] valve_command;
    logic       error_alarm;
    logic [1:0] phase;
  } result_t;

  typedef struct packed {
    logic [MOISTURE_BITS-1:0] moisture_target;
    logic [TICK_BITS-1:0]     idle_interval;
    logic [TICK_BITS-1:0]     watering_interval;
  } cfg_t;

endpackage

/* src/mws_cfg.sv */
// Configuration register file of the moisture watering sequencer.
module mws_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mws_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mws_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output mws_pkg::cfg_t                      cfg
);

  logic wr;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.moisture_target   <= mws_pkg::TARGET_RST;
      cfg.idle_interval     <= mws_pkg::IDLE_RST;
      cfg.watering_interval <= mws_pkg::WATER_RST;
    end else if (wr) begin
      if (cfg_index == mws_pkg::CFG_TARGET) begin
        cfg.moisture_target <= cfg_data[mws_pkg::MOISTURE_BITS-1:0];
      end
      if (cfg_index == mws_pkg::CFG_IDLE) begin
        cfg.idle_interval <= cfg_data[mws_pkg::TICK_BITS-1:0];
      end
      if (cfg_index == mws_pkg::CFG_WATER) begin
        cfg.watering_interval <= cfg_data[mws_pkg::TICK_BITS-1:0];
      end
    end
  end

endmodule

/* src/mws_seq.sv */
// Phase sequencer: state registers and the per-tick next-state and result logic.
module mws_seq #(
  parameter int FAIL_LIMIT = mws_pkg::FAIL_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mws_pkg::tick_t   tick,
  input  mws_pkg::cfg_t    cfg,
  output mws_pkg::result_t res
);

  localparam int MW     = mws_pkg::MOISTURE_BITS;
  localparam int TW     = mws_pkg::TICK_BITS;
  localparam int FAIL_W = $clog2(FAIL_LIMIT + 1);
  localparam logic [FAIL_W-1:0] FAIL_MAX = FAIL_W'(FAIL_LIMIT);
  localparam logic [MW:0]       MARGIN   = (MW + 1)'(mws_pkg::RISE_MARGIN);

  logic [1:0]        phase_reg, phase_next;
  logic [TW-1:0]     tick_left, tick_left_next;
  logic [MW-1:0]     last_moisture, last_moisture_next;
  logic [FAIL_W-1:0] fail_count, fail_count_next;
  logic              ready_pending, ready_pending_next;

  logic          rp;
  logic          dry;
  logic          rose;
  logic [1:0]    take_phase;
  logic [TW-1:0] take_ticks;
  logic [1:0]    take_valve;

  // Decode a ready reading against the target and the previous reading
  always_comb begin
    rp   = tick.event_valid ? (tick.event_kind == mws_pkg::EV_READY) : ready_pending;
    dry  = ({1'b0, tick.moisture} + MARGIN) < {1'b0, cfg.moisture_target};
    rose = {1'b0, tick.moisture} > ({1'b0, last_moisture} + MARGIN);
    if (dry) begin
      take_phase = mws_pkg::PH_WATER;
      take_ticks = cfg.watering_interval;
      take_valve = mws_pkg::VALVE_OPEN;
    end else begin
      take_phase = mws_pkg::PH_IDLE;
      take_ticks = cfg.idle_interval;
      take_valve = mws_pkg::VALVE_NONE;
    end
  end

  // Advance the phase for one tick
  always_comb begin
    phase_next         = phase_reg;
    tick_left_next     = tick_left;
    last_moisture_next = last_moisture;
    fail_count_next    = fail_count;
    ready_pending_next = rp;
    res.sense_request  = 1'b0;
    res.valve_command  = mws_pkg::VALVE_NONE;
    res.error_alarm    = 1'b0;
    unique case (phase_reg)
      mws_pkg::PH_IDLE, mws_pkg::PH_WATER: begin
        // Count down; drop any event seen meanwhile
        ready_pending_next = 1'b0;
        if (tick_left != '0) begin
          tick_left_next = tick_left - TW'(1);
        end else begin
          res.sense_request = 1'b1;
          if (phase_reg == mws_pkg::PH_WATER) begin
            res.valve_command = mws_pkg::VALVE_CLOSE;
            phase_next        = mws_pkg::PH_SENSE;
          end else begin
            phase_next = mws_pkg::PH_CHECK;
          end
        end
      end
      mws_pkg::PH_CHECK, mws_pkg::PH_SENSE: begin
        if (rp) begin
          phase_next         = take_phase;
          tick_left_next     = take_ticks;
          res.valve_command  = take_valve;
          last_moisture_next = tick.moisture;
          ready_pending_next = 1'b0;
          // Track consecutive failed waterings after the sense phase only
          if (phase_reg == mws_pkg::PH_SENSE) begin
            if (rose) begin
              fail_count_next = '0;
            end else if (fail_count < FAIL_MAX) begin
              fail_count_next = fail_count + FAIL_W'(1);
              res.error_alarm = (fail_count_next == FAIL_MAX);
            end
          end
        end
      end
      default: begin
        phase_next = phase_reg;
      end
    endcase
    res.phase = phase_next;
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= mws_pkg::PH_IDLE;
      tick_left     <= '0;
      last_moisture <= '0;
      fail_count    <= '0;
      ready_pending <= 1'b0;
    end else if (step) begin
      phase_reg     <= phase_next;
      tick_left     <= tick_left_next;
      last_moisture <= last_moisture_next;
      fail_count    <= fail_count_next;
      ready_pending <= ready_pending_next;
    end
  end

  a_alarm_from_sense: assert property (@(posedge clk) disable iff (rst)
    (step && res.error_alarm) |-> (phase_reg == mws_pkg::PH_SENSE))
    else $error("alarm raised outside the sense phase");

  a_close_at_end: assert property (@(posedge clk) disable iff (rst)
    (step && res.valve_command == mws_pkg::VALVE_CLOSE) |->
      (phase_reg == mws_pkg::PH_WATER && tick_left == '0))
    else $error("valve closed before the watering countdown expired");

  a_phase_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> (phase_reg == $past(res.phase)))
    else $error("reported phase does not match the stored phase");

  a_fail_bound: assert property (@(posedge clk) disable iff (rst)
    fail_count <= FAIL_MAX)
    else $error("failure count passed its limit");

  a_pending_cleared: assert property (@(posedge clk) disable iff (rst)
    (step && (phase_reg == mws_pkg::PH_IDLE || phase_reg == mws_pkg::PH_WATER))
      |=> !ready_pending)
    else $error("event kept pending across a countdown tick");

endmodule

/* src/moisture_watering_sequencer_unit.sv */
// Top level of the moisture watering sequencer: tick register, sequencer, result register.
//
// Usage:
//   tick channel   (tick_valid / tick_stall / tick): one beat per time tick, carrying an
//                  optional event (ready reading or other) and a moisture sample.
//   result channel (result_valid / result_stall / result): exactly one beat per tick,
//                  with the sense request, valve command, alarm and the new phase.
//   cfg channel    (cfg_valid / cfg_ready / cfg_index / cfg_data): 0 target moisture,
//                  1 idle interval, 2 watering interval; cfg_ready is always high.
//                  Write only while no tick is in flight.
// Path: a taken tick passes the tick register, then the result register. Throughput:
//   one tick per cycle while the result register is free or draining; the phase update
//   is one level of compare and count logic between the two registers.
// Reset (rst, synchronous): phase idle with a zero countdown, so the first tick
//   requests a reading; registers return to 2048 / 1000 / 100.
// Stall: while result_stall holds a full result register, the tick register takes a beat
//   only if it is empty; tick_stall is high while it holds one, until the result beat leaves.
module moisture_watering_sequencer_unit #(
  parameter int FAIL_LIMIT = mws_pkg::FAIL_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tick_valid,
  output logic                               tick_stall,
  input  mws_pkg::tick_t                     tick,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mws_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mws_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mws_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  mws_pkg::cfg_t    cfg;
  mws_pkg::tick_t   tick_q;
  mws_pkg::result_t res;
  logic             tick_q_valid;
  logic             advance;
  logic             step;

  // Move forward whenever the result register is free or being drained
  assign advance    = !result_valid || !result_stall;
  assign tick_stall = tick_q_valid && !advance;
  assign step       = tick_q_valid && advance;

  mws_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mws_seq #(
    .FAIL_LIMIT (FAIL_LIMIT)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .tick (tick_q),
    .cfg  (cfg),
    .res  (res)
  );

  // Capture the incoming tick beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (!tick_stall) begin
      tick_q_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      tick_q <= tick;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= tick_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= res;
    end
  end

endmodule
